// ===== design/b64lw_pkg.sv =====
// Shared types, constants and the Base64 alphabet for the line-wrapped encoder.
// No dependencies; used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

  localparam int LINE_W = 7;          // width of the characters-on-line counter
  localparam int QUEUE_DEPTH = 2;     // jobs between front and back

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  typedef enum logic [1:0] {
    JOB_GROUP,       // four characters
    JOB_GROUP_CRLF,  // four characters, then CR LF
    JOB_TAIL1,       // two characters and "=="
    JOB_TAIL2        // three characters and "="
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] grp;  // three bytes, oldest in the high byte
  } job_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64lw_front.sv =====
// Front end: takes bytes, keeps the pending bytes and line position, and
// turns each byte into an output job (or none). Uses b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_front #(
  parameter int LINE_CHARS = 76
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_tdata,
  input  wire                 in_tlast,
  input  wire                 q_full,
  output logic                q_push,
  output b64lw_pkg::job_t     q_job
);

  logic [15:0]                     pend_r, pend_nxt;
  logic [1:0]                      cnt_r, cnt_nxt;
  logic [b64lw_pkg::LINE_W-1:0]    line_r, line_nxt;
  logic [b64lw_pkg::LINE_W-1:0]    line_sum;
  logic                            accept;

  assign in_tready = !q_full;
  assign accept = in_tvalid && in_tready;
  assign line_sum = line_r + b64lw_pkg::LINE_W'(4);

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt = cnt_r;
    line_nxt = line_r;
    q_push = 1'b0;
    q_job.kind = b64lw_pkg::JOB_GROUP;
    q_job.grp = {pend_r, in_tdata};
    if (accept) begin
      if (cnt_r[1]) begin
        q_push = 1'b1;
        pend_nxt = '0;
        cnt_nxt = '0;
        if (line_sum >= b64lw_pkg::LINE_W'(LINE_CHARS)) begin
          q_job.kind = b64lw_pkg::JOB_GROUP_CRLF;
          line_nxt = '0;
        end else begin
          line_nxt = line_sum;
        end
      end else begin
        pend_nxt = {pend_r[7:0], in_tdata};
        cnt_nxt = cnt_r + 2'd1;
        if (in_tlast) begin
          q_push = 1'b1;
          if (cnt_r == 2'd0) begin
            q_job.kind = b64lw_pkg::JOB_TAIL1;
            q_job.grp = {in_tdata, 16'h0000};
          end else begin
            q_job.kind = b64lw_pkg::JOB_TAIL2;
            q_job.grp = {pend_r[7:0], in_tdata, 8'h00};
          end
        end
      end
      // end of message: everything back to the start-of-message state
      if (in_tlast) begin
        pend_nxt = '0;
        cnt_nxt = '0;
        line_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r <= '0;
      line_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r <= cnt_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64lw_fifo.sv =====
// Two-entry first-word-fall-through job queue between front and back.
// Uses b64lw_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire b64lw_pkg::job_t  push_job,
  output logic                  full,
  input  wire                   pop,
  output logic                  head_valid,
  output b64lw_pkg::job_t       head_job
);

  localparam int PTR_W = $clog2(b64lw_pkg::QUEUE_DEPTH);

  b64lw_pkg::job_t        mem_r [b64lw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]         cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full = (cnt_r == (PTR_W+1)'(b64lw_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b64lw_back.sv =====
// Back end: walks the head job into the output register one character per cycle
// while the output side is not stalled, padding and CR LF included. Uses b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  input  wire b64lw_pkg::job_t  q_job,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);

  logic [2:0]  idx_r, idx_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [7:0]  out_tdata_r, out_tdata_nxt;
  logic        out_tlast_r, out_tlast_nxt;
  logic        load;
  logic [2:0]  last_idx;
  logic [5:0]  sx;
  logic [7:0]  ch;

  assign load = q_valid && (!out_tvalid_r || out_tready);
  assign last_idx = (q_job.kind == b64lw_pkg::JOB_GROUP_CRLF) ? 3'd5 : 3'd3;
  assign q_pop = load && (idx_r == last_idx);

  always_comb begin
    case (idx_r)
      3'd0:    sx = q_job.grp[23:18];
      3'd1:    sx = q_job.grp[17:12];
      3'd2:    sx = q_job.grp[11:6];
      default: sx = q_job.grp[5:0];
    endcase
  end

  always_comb begin
    ch = b64lw_pkg::sextet_char(sx);
    if (idx_r == 3'd4) begin
      ch = b64lw_pkg::CHAR_CR;
    end else if (idx_r == 3'd5) begin
      ch = b64lw_pkg::CHAR_LF;
    end else if (q_job.kind == b64lw_pkg::JOB_TAIL1 && idx_r >= 3'd2) begin
      ch = b64lw_pkg::CHAR_PAD;
    end else if (q_job.kind == b64lw_pkg::JOB_TAIL2 && idx_r == 3'd3) begin
      ch = b64lw_pkg::CHAR_PAD;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt = out_tdata_r;
    out_tlast_nxt = out_tlast_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt = ch;
      out_tlast_nxt = q_pop;
      idx_nxt = q_pop ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      out_tvalid_r <= 1'b0;
      out_tlast_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_tlast_r <= out_tlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tlast = out_tlast_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'd5)
    else $error("character index out of range");

  a_mid_job_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> q_valid)
    else $error("job left the queue before its last character");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid_r && out_tlast_r)
    else $error("finished job did not mark its last character");

  a_crlf_only_long: assert property (@(posedge clk) disable iff (!rst_n)
    load && idx_r >= 3'd4 |-> q_job.kind == b64lw_pkg::JOB_GROUP_CRLF)
    else $error("line break emitted for a job without one");

endmodule

`default_nettype wire

// ===== design/base64_line_wrapped_encoder.sv =====
// Channel  Dir  tdata (low bit up)   tuser  tlast
// in_      in   data_byte[7:0]       -      last_byte
// out_     out  out_char[7:0]        -      run_last
//
// One character leaves per cycle from the back-end serializer while out_tready is
// high; a byte yields 0 to 6 characters, 4/3 on average in a long message (LINE_CHARS
// adds 2 per line). Bytes are taken while the two-entry job queue has room.
// Reset (rst_n low, synchronous) empties the queue and output register and
// clears the pending bytes and line position. Either side may stall freely.
// Depends on b64lw_pkg, b64lw_front, b64lw_fifo and b64lw_back.
`timescale 1ns / 1ps
`default_nettype none

module base64_line_wrapped_encoder #(
  parameter int LINE_CHARS = 76
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] data_byte
  input  wire        in_tlast,
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast
);

  logic             q_full, q_push, q_pop, q_valid;
  b64lw_pkg::job_t  push_job, head_job;

  b64lw_front #(.LINE_CHARS(LINE_CHARS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64lw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  b64lw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
